// ----- design/mdee_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the maze dead-end explorer.
// No dependencies; imported by every design file.
package mdee_pkg;

    localparam int MAZE_SIDE = 32;
    localparam int COORD_W   = $clog2(MAZE_SIDE);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 5;

    localparam logic [COORD_W-1:0] COORD_MAX   = COORD_W'(MAZE_SIDE - 1);
    localparam logic [COORD_W-1:0] START_X     = COORD_W'(1);
    localparam logic [COORD_W-1:0] START_Y     = COORD_W'(1);
    localparam logic [COORD_W-1:0] GOAL_X_RST  = COORD_W'(12);
    localparam logic [COORD_W-1:0] GOAL_Y_RST  = COORD_W'(8);

    localparam logic [CFG_IDX_W-1:0] REG_GOAL_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y = CFG_IDX_W'(1);

    // absolute directions; bit d of a side mask is direction d
    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    localparam logic [2:0] MOVE_NONE = 3'd0;

    typedef struct packed {
        logic               rd_en;
        logic [COORD_W-1:0] rd_row;
        logic               wr_en;
        logic [COORD_W-1:0] wr_row;
        logic [COORD_W-1:0] wr_col;
    } map_req_t;

    typedef struct packed {
        logic       move;
        logic [1:0] dir;
        logic       mark;
    } dec_t;

    // 15-bit value mod 3: base-4 digits each weigh 1 mod 3
    function automatic logic [1:0] mod3_15(input logic [14:0] v);
        logic [4:0] s;
        logic [2:0] t;
        s = 5'(v[14]);
        for (int i = 0; i < 7; i++) begin
            s = s + 5'(v[2*i +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

endpackage

// ----- design/mdee_map_mem.sv -----
`timescale 1ns / 1ps
// Dead-end map: MAZE_SIDE rows of MAZE_SIDE bits, one read port with registered data.
// Per-row valid flops clear the whole map at reset. Depends on mdee_pkg.
module mdee_map_mem
    import mdee_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  map_req_t             req,
    output logic [MAZE_SIDE-1:0] rd_data
);

    logic [MAZE_SIDE-1:0] mem [MAZE_SIDE];
    logic [MAZE_SIDE-1:0] row_vld_reg;
    logic [MAZE_SIDE-1:0] rd_data_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                row_vld_reg[req.wr_row] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= row_vld_reg[req.rd_row];
            end
        end
    end

    // first write to a stale row clears the rest of it
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            if (row_vld_reg[req.wr_row])
            begin
                mem[req.wr_row][req.wr_col] <= 1'b1;
            end
            else
            begin
                mem[req.wr_row] <= MAZE_SIDE'(1) << req.wr_col;
            end
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_row];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ----- design/mdee_decide.sv -----
`timescale 1ns / 1ps
// Direction choice for one step: open sides, corridor following, random pick.
// Depends on mdee_pkg.
module mdee_decide
    import mdee_pkg::*;
(
    input  logic [3:0] walls,
    input  logic [3:0] marks,
    input  logic [1:0] last_dir,
    input  logic       rnd_mod2,
    input  logic [1:0] rnd_mod3,
    output dec_t       dec
);

    logic [3:0] open_mask;
    logic [3:0] cand_mask;
    logic [2:0] n_open;
    logic [1:0] rev;
    logic [3:0] pick_mask;
    logic [1:0] pick_idx;
    logic       pick_found;
    logic [1:0] pick_dir;
    logic [1:0] seen;

    assign open_mask = ~walls & ~marks;
    assign rev       = last_dir + 2'd2;
    assign cand_mask = open_mask & ~(4'b0001 << rev);

    always_comb
    begin
        n_open = '0;
        for (int d = 0; d < 4; d++)
        begin
            n_open = n_open + 3'(open_mask[d]);
        end
    end

    always_comb
    begin
        pick_mask = '0;
        pick_idx  = '0;
        unique case (n_open)
            3'd0:    pick_mask = '0;
            3'd1:    pick_mask = open_mask;
            3'd2:    pick_mask = cand_mask;
            3'd3:
            begin
                pick_mask = cand_mask;
                pick_idx  = {1'b0, rnd_mod2};
            end
            default:
            begin
                pick_mask = cand_mask;
                pick_idx  = rnd_mod3;
            end
        endcase
    end

    // select the pick_idx-th set bit in N, E, S, W order
    always_comb
    begin
        pick_found = 1'b0;
        pick_dir   = DIR_N;
        seen       = '0;
        for (int d = 0; d < 4; d++)
        begin
            if (pick_mask[d])
            begin
                if (!pick_found && seen == pick_idx)
                begin
                    pick_found = 1'b1;
                    pick_dir   = 2'(d);
                end
                seen = seen + 2'd1;
            end
        end
    end

    assign dec.move = pick_found;
    assign dec.dir  = pick_dir;
    assign dec.mark = (n_open == 3'd1);

endmodule

// ----- design/maze_dead_end_explorer_top.sv -----
`timescale 1ns / 1ps
// Maze dead-end explorer: step sequencer, position state, config and output register.
// Depends on mdee_pkg, mdee_map_mem and mdee_decide.
// Each item takes three map row reads (north, south, current) through the single
// read port, then a decide/update step that a full output stalls; a new item is
// accepted no earlier than the update step that completes the current one.
// Reset: position (1,1), heading north, goal (12,8); per-row valid flops clear the map.
module maze_dead_end_explorer_top
    import mdee_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 wall_north,
    input  logic                 wall_east,
    input  logic                 wall_south,
    input  logic                 wall_west,
    input  logic [14:0]          random_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           move_dir,
    output logic [COORD_W-1:0]   cell_x,
    output logic [COORD_W-1:0]   cell_y,
    output logic                 finished
);

    localparam logic [1:0] PH_RD_N = 2'd0;
    localparam logic [1:0] PH_RD_S = 2'd1;
    localparam logic [1:0] PH_RD_C = 2'd2;
    localparam logic [1:0] PH_EXEC = 2'd3;

    logic [1:0]           phase_reg, phase_next;
    logic                 in_full_reg;
    logic [3:0]           walls_reg;
    logic                 rnd_mod2_reg;
    logic [1:0]           rnd_mod3_reg;
    logic                 mark_n_reg, mark_s_reg;
    logic [COORD_W-1:0]   pos_x_reg, pos_y_reg, pos_x_next, pos_y_next;
    logic [1:0]           last_dir_reg;
    logic                 goal_reached_reg, goal_reached_next;
    logic [COORD_W-1:0]   goal_x_reg, goal_y_reg;
    logic                 out_valid_reg;
    logic [2:0]           move_dir_reg;
    logic [COORD_W-1:0]   cell_x_reg, cell_y_reg;
    logic                 finished_reg;

    logic                 in_xfer;
    logic                 exec;
    logic                 out_space;
    logic                 done;
    logic                 mark_e, mark_w;
    logic                 do_move;
    map_req_t             map_req;
    logic [MAZE_SIDE-1:0] rd_data;
    dec_t                 dec;

    assign in_xfer   = in_valid && in_ready;
    assign exec      = in_full_reg && (phase_reg == PH_EXEC);
    assign out_space = !out_valid_reg || out_ready;
    assign done      = exec && out_space;
    assign in_ready  = !in_full_reg || done;

    always_comb
    begin
        phase_next = phase_reg;
        if (in_full_reg)
        begin
            unique case (phase_reg)
                PH_RD_N: phase_next = PH_RD_S;
                PH_RD_S: phase_next = PH_RD_C;
                PH_RD_C: phase_next = PH_EXEC;
                PH_EXEC: phase_next = done ? PH_RD_N : PH_EXEC;
                default: phase_next = PH_RD_N;
            endcase
        end
    end

    always_comb
    begin
        map_req.rd_en  = in_full_reg && (phase_reg != PH_EXEC);
        map_req.rd_row = pos_y_reg;
        unique case (phase_reg)
            PH_RD_N: map_req.rd_row = pos_y_reg + COORD_W'(1);
            PH_RD_S: map_req.rd_row = pos_y_reg - COORD_W'(1);
            default: map_req.rd_row = pos_y_reg;
        endcase
        map_req.wr_en  = done && dec.mark && !goal_reached_reg;
        map_req.wr_row = pos_y_reg;
        map_req.wr_col = pos_x_reg;
    end

    mdee_map_mem u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (map_req),
        .rd_data (rd_data)
    );

    // neighbors past the map edge read as unmarked
    assign mark_e = (pos_x_reg != COORD_MAX) && rd_data[pos_x_reg + COORD_W'(1)];
    assign mark_w = (pos_x_reg != '0) && rd_data[pos_x_reg - COORD_W'(1)];

    mdee_decide u_decide (
        .walls    (walls_reg),
        .marks    ({mark_w, mark_s_reg, mark_e, mark_n_reg}),
        .last_dir (last_dir_reg),
        .rnd_mod2 (rnd_mod2_reg),
        .rnd_mod3 (rnd_mod3_reg),
        .dec      (dec)
    );

    assign do_move = dec.move && !goal_reached_reg;

    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        if (do_move)
        begin
            unique case (dec.dir)
                DIR_N:   pos_y_next = pos_y_reg + COORD_W'(1);
                DIR_E:   pos_x_next = pos_x_reg + COORD_W'(1);
                DIR_S:   pos_y_next = pos_y_reg - COORD_W'(1);
                DIR_W:   pos_x_next = pos_x_reg - COORD_W'(1);
                default: pos_x_next = pos_x_reg;
            endcase
        end
        goal_reached_next = goal_reached_reg
                          || (pos_x_next == goal_x_reg && pos_y_next == goal_y_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_RD_N;
            in_full_reg      <= 1'b0;
            pos_x_reg        <= START_X;
            pos_y_reg        <= START_Y;
            last_dir_reg     <= DIR_N;
            goal_reached_reg <= 1'b0;
            goal_x_reg       <= GOAL_X_RST;
            goal_y_reg       <= GOAL_Y_RST;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (in_xfer)
            begin
                in_full_reg <= 1'b1;
            end
            else if (done)
            begin
                in_full_reg <= 1'b0;
            end

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_GOAL_X: goal_x_reg <= cfg_data;
                    REG_GOAL_Y: goal_y_reg <= cfg_data;
                    default:    goal_x_reg <= goal_x_reg;
                endcase
            end

            if (done)
            begin
                pos_x_reg        <= pos_x_next;
                pos_y_reg        <= pos_y_next;
                goal_reached_reg <= goal_reached_next;
                if (do_move)
                begin
                    last_dir_reg <= dec.dir;
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            walls_reg    <= {wall_west, wall_south, wall_east, wall_north};
            rnd_mod2_reg <= random_value[0];
            rnd_mod3_reg <= mod3_15(random_value);
        end
        if (in_full_reg && phase_reg == PH_RD_S)
        begin
            mark_n_reg <= (pos_y_reg != COORD_MAX) && rd_data[pos_x_reg];
        end
        if (in_full_reg && phase_reg == PH_RD_C)
        begin
            mark_s_reg <= (pos_y_reg != '0) && rd_data[pos_x_reg];
        end
        if (done)
        begin
            move_dir_reg <= do_move ? (3'(dec.dir) + 3'd1) : MOVE_NONE;
            cell_x_reg   <= pos_x_next;
            cell_y_reg   <= pos_y_next;
            finished_reg <= goal_reached_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign move_dir  = move_dir_reg;
    assign cell_x    = cell_x_reg;
    assign cell_y    = cell_y_reg;
    assign finished  = finished_reg;

    // sequencer only leaves the first phase with an item on hand
    a_phase_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_RD_N) |-> in_full_reg)
        else $error("sequencer past first phase with no item");

    // map write never overlaps a map read
    a_no_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
        map_req.wr_en |-> (!map_req.rd_en && phase_reg == PH_EXEC))
        else $error("map write outside the update cycle");

    // finish flag is sticky
    a_goal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        goal_reached_reg |=> goal_reached_reg)
        else $error("goal flag dropped");

    // a move always changes the position
    a_move_changes_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (done && do_move) |=> (pos_x_reg != $past(pos_x_reg)
                               || pos_y_reg != $past(pos_y_reg)))
        else $error("move without position change");

endmodule
